/* sv/lgge_pkg.sv */
package lgge_pkg;

    // Field widths of the stream words.
    localparam int COORD_W   = 5;
    localparam int COORD_SPAN = 32;
    localparam int REQ_W     = 2;
    localparam int GEN_W     = 32;
    localparam int CFG_W     = 6;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 40;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Request codes carried in s_tuser.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    // Result kinds carried in m_tuser.
    localparam logic RES_READ = 1'b0;
    localparam logic RES_STEP = 1'b1;

    // Register select, taken from paddr bit 2.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 6'd30;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 6'd30;

endpackage

/* sv/lgge_row_update.sv */
// Next-generation value of one grid row, all columns in parallel.
module lgge_row_update #(
    parameter int MAX_W = 32,
    parameter int UW    = 6
) (
    input  logic [MAX_W-1:0] row_up,
    input  logic [MAX_W-1:0] row_mid,
    input  logic [MAX_W-1:0] row_dn,
    input  logic [UW-1:0]    used_w,
    output logic [MAX_W-1:0] row_new
);

    logic [MAX_W+1:0] pad_up;
    logic [MAX_W+1:0] pad_mid;
    logic [MAX_W+1:0] pad_dn;

    // One dead column on each side so that the edge lanes index safely.
    assign pad_up  = {1'b0, row_up, 1'b0};
    assign pad_mid = {1'b0, row_mid, 1'b0};
    assign pad_dn  = {1'b0, row_dn, 1'b0};

    always_comb begin
        logic [3:0] n;
        logic       inner;
        for (int x = 0; x < MAX_W; x++) begin
            n = 4'(pad_up[x]) + 4'(pad_up[x+1]) + 4'(pad_up[x+2])
              + 4'(pad_mid[x]) + 4'(pad_mid[x+2])
              + 4'(pad_dn[x]) + 4'(pad_dn[x+1]) + 4'(pad_dn[x+2]);
            // Only columns strictly inside the width in use are computed.
            inner = (x != 0) && ((UW'(x) + UW'(2)) <= used_w);
            row_new[x] = inner && ((n == 4'd3) || ((n == 4'd2) && row_mid[x]));
        end
    end

endmodule

/* sv/life_grid_generation_engine_top.sv */
// Life grid engine: a one-bit cell grid of up to MAX_W by MAX_H cells that runs Conway's
// rule (birth on three neighbors, survival on two or three). Each input word is a request
// selected by s_tuser: write one cell, read one cell, or compute one generation. A write
// gives no result word; a read returns the cell (0 outside the configured area); a step
// returns the new generation count. The grid is kept in one memory with one row of MAX_W
// cells per entry, so a write is a read-modify-write of its row, a read goes through the
// memory read register to the output register, and a step sweeps the rows in use one
// row per cycle from the single memory read port while writing back the row two above it,
// which it already holds in a three-row window.
// The outermost rows and columns of the configured area, and all cells outside it, are
// dead after a step. After reset the grid reads as all dead at once: each row carries a
// valid flag, so no clearing pass is needed. A result word waits in the output register
// while the next request is accepted. grid_width and grid_height may be written only
// while no request is in flight.
module life_grid_generation_engine_top
    import lgge_pkg::*;
#(
    parameter int MAX_W = 32,
    parameter int MAX_H = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [4:0] cell_x, [9:5] cell_y, [10] cell_value, [15:11] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]      s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] read_value, [32:1] generation, [39:33] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    // [0] result_kind
    output logic                  m_tuser,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RW = $clog2(MAX_H);
    localparam int UW = ($clog2(MAX_W + 1) > CFG_W) ? $clog2(MAX_W + 1) : CFG_W;
    localparam int UH = ($clog2(MAX_H + 1) > CFG_W) ? $clog2(MAX_H + 1) : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CELL  = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic             cfg_wr;

    // Captured request.
    logic [REQ_W-1:0]   req_type_reg;
    logic [COORD_W-1:0] req_x_reg;
    logic [COORD_W-1:0] req_y_reg;
    logic               req_v_reg;

    // Grid memory, one row per entry, and a valid flag per row.
    logic [MAX_W-1:0] grid_mem [MAX_H];
    logic [MAX_H-1:0] row_valid_reg, row_valid_next;
    logic             rd_en;
    logic [RW-1:0]    rd_addr;
    logic [MAX_W-1:0] rd_data_reg;
    logic             rd_ok_reg;
    logic [MAX_W-1:0] rd_row;
    logic             mem_we;
    logic [RW-1:0]    mem_waddr;
    logic [MAX_W-1:0] mem_wdata;

    // Step sweep.
    logic [UH-1:0]    cnt_reg, cnt_next;
    logic [MAX_W-1:0] up_reg;
    logic [MAX_W-1:0] mid_reg;
    logic [MAX_W-1:0] sweep_row;
    logic [GEN_W-1:0] gen_reg, gen_next;

    // Output register.
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_kind_reg, m_kind_next;
    logic                m_value_reg, m_value_next;
    logic [GEN_W-1:0]    m_gen_reg, m_gen_next;
    logic                out_free;

    // Area in use and cell selection.
    logic [UW-1:0]    used_w;
    logic [UH-1:0]    used_h;
    logic             cell_in_area;
    logic [MAX_W-1:0] cell_sel;
    logic [MAX_W-1:0] cell_row;
    logic [MAX_H-1:0] keep_rows;
    logic             in_acc;

    assign used_w = (UW'(grid_width_reg) < UW'(MAX_W)) ? UW'(grid_width_reg) : UW'(MAX_W);
    assign used_h = (UH'(grid_height_reg) < UH'(MAX_H)) ? UH'(grid_height_reg) : UH'(MAX_H);

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= WIDTH_RESET;
            grid_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_WIDTH:  grid_width_reg  <= pwdata[CFG_W-1:0];
                CFG_HEIGHT: grid_height_reg <= pwdata[CFG_W-1:0];
                default:    grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            CFG_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input side
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            req_type_reg <= s_tuser;
            req_x_reg    <= s_tdata[COORD_W-1:0];
            req_y_reg    <= s_tdata[2*COORD_W-1:COORD_W];
            req_v_reg    <= s_tdata[2*COORD_W];
        end
    end

    assign cell_in_area = (UW'(req_x_reg) < used_w) && (UH'(req_y_reg) < used_h);

    // One-hot column select for the requested cell; columns beyond the
    // coordinate range never match.
    always_comb begin
        for (int i = 0; i < MAX_W; i++) begin
            cell_sel[i] = (i < COORD_SPAN) && (req_x_reg == COORD_W'(i));
        end
    end

    // ---------------------------------------------------------------- grid memory
    // A row whose valid flag is clear reads as all dead.
    assign rd_row = rd_data_reg & {MAX_W{rd_ok_reg}};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= grid_mem[rd_addr];
            rd_ok_reg   <= row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else begin
            row_valid_reg <= row_valid_next;
        end
    end

    // The cell write replaces one bit of the row just read.
    assign cell_row = (rd_row & ~cell_sel) | (cell_sel & {MAX_W{req_v_reg}});

    lgge_row_update #(
        .MAX_W (MAX_W),
        .UW    (UW)
    ) u_row_update (
        .row_up  (up_reg),
        .row_mid (mid_reg),
        .row_dn  (rd_row),
        .used_w  (used_w),
        .row_new (sweep_row)
    );

    // Rows strictly inside the height in use survive the end of a step.
    always_comb begin
        for (int r = 0; r < MAX_H; r++) begin
            keep_rows[r] = (r != 0) && ((UH'(r) + UH'(2)) <= used_h);
        end
    end

    // The window shifts as each row of the sweep arrives from memory.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SWEEP) && (cnt_reg != '0)) begin
            up_reg  <= mid_reg;
            mid_reg <= rd_row;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gen_next       = gen_reg;
        row_valid_next = row_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = RW'(s_tdata[2*COORD_W-1:COORD_W]);
        mem_we         = 1'b0;
        mem_waddr      = RW'(req_y_reg);
        mem_wdata      = cell_row;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_value_next   = m_value_reg;
        m_gen_next     = m_gen_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        REQ_WRITE, REQ_READ: begin
                            rd_en      = 1'b1;
                            state_next = ST_CELL;
                        end
                        REQ_STEP: begin
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CELL: begin
                if (req_type_reg == REQ_WRITE) begin
                    if (cell_in_area) begin
                        mem_we                             = 1'b1;
                        row_valid_next[RW'(req_y_reg)]     = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // The read row stays in the read register until the output frees up.
                    m_tvalid_next = 1'b1;
                    m_kind_next   = RES_READ;
                    m_value_next  = cell_in_area && |(rd_row & cell_sel);
                    m_gen_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                // Count c issues the read of row c and takes in row c-1; from c = 3 on
                // the window yields the new row c-2.
                rd_addr = cnt_reg[RW-1:0];
                rd_en   = (cnt_reg < used_h);
                if (cnt_reg >= UH'(3)) begin
                    mem_we                     = 1'b1;
                    mem_waddr                  = RW'(cnt_reg - UH'(2));
                    mem_wdata                  = sweep_row;
                    row_valid_next[mem_waddr]  = 1'b1;
                end
                if (cnt_reg == used_h) begin
                    row_valid_next = row_valid_next & keep_rows;
                    gen_next       = gen_reg + GEN_W'(1);
                    state_next     = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + UH'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = RES_STEP;
                    m_value_next  = 1'b0;
                    m_gen_next    = gen_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            gen_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            gen_reg      <= gen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_gen_reg   <= m_gen_next;
    end

    // ---------------------------------------------------------------- output side
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {(M_DATA_W - GEN_W - 1)'(0), m_gen_reg, m_value_reg};

endmodule

/* tb/tb_top.sv */
module tb_top;
    import lgge_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int GRID_MAX = 32;
    // Request type 3 has no meaning; the engine must swallow it without a result.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // A step on 32 rows is the longest request of all; a write that gives no result
    // may still be busy up to that long after the last result word.
    localparam int SETTLE_CYCLES = 40;
    // Long hold-off of the result side, so that the output register and the
    // request path fill up and s_tready has to drop.
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 30;
    // Watchdog limit, many times the length of the slowest correct run.
    localparam int LIMIT_CYCLES = 500000;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic             kind;
        logic             value;
        logic [GEN_W-1:0] count;
    } life_result_t;

    // Predictor of the life engine plus the queue of result words it expects.
    class life_grid_predictor;
        logic [GRID_MAX-1:0] rows [GRID_MAX];
        logic [GEN_W-1:0]    generation;
        logic [CFG_W-1:0]    width_reg;
        logic [CFG_W-1:0]    height_reg;
        life_result_t        due_results [$];
        int                  errors;

        function new();
            for (int r = 0; r < GRID_MAX; r++) rows[r] = '0;
            generation = '0;
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors = 0;
        endfunction

        function int span(logic [CFG_W-1:0] reg_value);
            return (reg_value > GRID_MAX) ? GRID_MAX : int'(reg_value);
        endfunction

        function void set_register(logic sel, logic [CFG_W-1:0] value);
            if (sel == CFG_WIDTH) width_reg = value;
            else height_reg = value;
        endfunction

        function logic [CFG_W-1:0] register_value(logic sel);
            return (sel == CFG_WIDTH) ? width_reg : height_reg;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_mismatch(string msg);
            errors++;
            if (errors <= REPORT_MAX) $display("MISMATCH: %s", msg);
        endfunction

        // One Conway generation: only cells strictly inside the area in use
        // are computed, everything else ends up dead.
        function void compute_generation();
            logic [GRID_MAX-1:0] nxt [GRID_MAX];
            int w;
            int h;
            int n;
            w = span(width_reg);
            h = span(height_reg);
            for (int r = 0; r < GRID_MAX; r++) nxt[r] = '0;
            for (int r = 1; r + 1 < h; r++) begin
                for (int c = 1; c + 1 < w; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0) n += int'(rows[r+dr][c+dc]);
                    if (n == 3) nxt[r][c] = 1'b1;
                    else if (n == 2) nxt[r][c] = rows[r][c];
                end
            end
            rows = nxt;
            generation = generation + 1'b1;
        endfunction

        function void apply_request(logic [REQ_W-1:0] req, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] y, logic v);
            bit           in_area;
            life_result_t res;
            in_area = (x < span(width_reg)) && (y < span(height_reg));
            case (req)
                REQ_WRITE: begin
                    if (in_area) rows[y][x] = v;
                end
                REQ_READ: begin
                    res.kind = RES_READ;
                    res.value = in_area ? rows[y][x] : 1'b0;
                    res.count = '0;
                    due_results.push_back(res);
                end
                REQ_STEP: begin
                    compute_generation();
                    res.kind = RES_STEP;
                    res.value = 1'b0;
                    res.count = generation;
                    due_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic kind, logic value, logic [GEN_W-1:0] count);
            life_result_t res;
            if (due_results.size() == 0) begin
                note_mismatch($sformatf("unexpected word kind %0d value %0d generation %0d",
                                        kind, value, count));
                return;
            end
            res = due_results.pop_front();
            if (kind !== res.kind || value !== res.value || count !== res.count)
                note_mismatch($sformatf(
                    "expected kind %0d value %0d generation %0d, got %0d %0d %0d",
                    res.kind, res.value, res.count, kind, value, count));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    life_grid_predictor engine_model = new();

    // Number of accepted requests that the engine acts on (type 3 is not counted).
    int requests_sent = 0;
    int words_offered = 0;
    // While set, the request side offers words back to back with no gaps.
    bit send_burst = 1'b0;

    life_grid_generation_engine_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Offers one request word after a random gap and returns at the edge where
    // it is taken. s_tvalid is left high, so a following word with no gap goes
    // out without a bubble and without a second assignment in the same step.
    task automatic offer(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y, input logic v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {{(S_DATA_W-2*COORD_W-1){1'b0}}, v, y, x};
        do @(posedge aclk); while (!s_tready);
        engine_model.apply_request(req, x, y, v);
        if (req != REQ_UNUSED) requests_sent++;
        words_offered++;
        if (words_offered % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
    endtask

    // Stops offering, waits for every expected word and then for the longest
    // request, so that a trailing write has surely landed in the grid.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (engine_model.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB transfer: setup, access, then back to idle. On a
    // read the value is the register content the predictor holds.
    task automatic apb_access(input logic wr, input logic sel, input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {sel, 2'b00};
        pwdata <= {{(APB_DATA_W-CFG_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr)
            engine_model.set_register(sel, value);
        else if (prdata[CFG_W-1:0] !== value)
            engine_model.note_mismatch($sformatf("register %0d read %0d, expected %0d",
                                                 sel, prdata[CFG_W-1:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        apb_access(1'b1, CFG_WIDTH, w);
        apb_access(1'b1, CFG_HEIGHT, h);
        apb_access(1'b0, CFG_WIDTH, engine_model.register_value(CFG_WIDTH));
        apb_access(1'b0, CFG_HEIGHT, engine_model.register_value(CFG_HEIGHT));
    endtask

    // Mostly a coordinate inside the area in use, sometimes anywhere in the
    // field's range so that out-of-range reads and writes keep turning up.
    function automatic logic [COORD_W-1:0] pick_coord(int span);
        if (span == 0 || $urandom_range(0, 7) == 0) return COORD_W'($urandom_range(0, 31));
        return COORD_W'($urandom_range(0, span - 1));
    endfunction

    // Random rounds of life: seed a handful of cells (often live, sometimes as
    // a bar of three that starts to oscillate), run a few generations, probe
    // some cells, and now and then throw in a word of noise.
    task automatic run_generations(input int budget);
        int stop_at;
        int uw;
        int uh;
        int cx;
        int cy;
        stop_at = requests_sent + budget;
        uw = engine_model.span(engine_model.width_reg);
        uh = engine_model.span(engine_model.height_reg);
        while (requests_sent < stop_at) begin
            repeat ($urandom_range(2, 10)) begin
                if (uw >= 3 && uh >= 1 && $urandom_range(0, 4) == 0) begin
                    cx = $urandom_range(1, uw - 2);
                    cy = $urandom_range(0, uh - 1);
                    for (int i = -1; i <= 1; i++)
                        offer(REQ_WRITE, COORD_W'(cx + i), COORD_W'(cy), 1'b1);
                end else begin
                    offer(REQ_WRITE, pick_coord(uw), pick_coord(uh),
                          $urandom_range(0, 3) != 0);
                end
            end
            // The coordinate fields of a step carry no meaning, so they get noise.
            repeat ($urandom_range(1, 3))
                offer(REQ_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 6))
                offer(REQ_READ, pick_coord(uw), pick_coord(uh), 1'($urandom));
            if ($urandom_range(0, 4) == 0)
                offer(REQ_W'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                      1'($urandom));
        end
    endtask

    // Result side: a random stall before every word, bursts with no stall at
    // all, and one long hold-off early in the run while requests keep coming.
    initial begin
        int stall;
        int taken;
        bit held;
        bit burst;
        taken = 0;
        held = 1'b0;
        burst = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 17);
            if (!held && taken == HOLD_AFTER) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            engine_model.check_result(m_tuser, m_tdata[0], m_tdata[GEN_W:1]);
            taken++;
            if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
        end
    end

    // Main sequence: reset, a directed opening on the reset size, then random
    // phases on a range of grid sizes with the size changed only while idle.
    initial begin
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Both registers must come up at their reset size.
        apb_access(1'b0, CFG_WIDTH, WIDTH_RESET);
        apb_access(1'b0, CFG_HEIGHT, HEIGHT_RESET);

        // A corner cell of the area is writable and readable until a step kills it.
        offer(REQ_WRITE, 5'd0, 5'd0, 1'b1);
        offer(REQ_READ, 5'd0, 5'd0, 1'b0);
        // Beyond a 30 by 30 area a write is dropped and a read gives 0.
        offer(REQ_WRITE, 5'd31, 5'd31, 1'b1);
        offer(REQ_READ, 5'd31, 5'd31, 1'b0);
        offer(REQ_WRITE, 5'd29, 5'd29, 1'b1);
        offer(REQ_READ, 5'd29, 5'd29, 1'b0);
        offer(REQ_WRITE, 5'd15, 5'd30, 1'b1);
        offer(REQ_READ, 5'd30, 5'd0, 1'b0);
        // The unused request type must not produce a word.
        offer(REQ_UNUSED, 5'd31, 5'd31, 1'b1);
        // A vertical blinker flips to horizontal and back.
        offer(REQ_WRITE, 5'd5, 5'd4, 1'b1);
        offer(REQ_WRITE, 5'd5, 5'd5, 1'b1);
        offer(REQ_WRITE, 5'd5, 5'd6, 1'b1);
        offer(REQ_STEP, 5'd0, 5'd0, 1'b0);
        offer(REQ_READ, 5'd4, 5'd5, 1'b0);
        offer(REQ_READ, 5'd5, 5'd4, 1'b0);
        offer(REQ_READ, 5'd6, 5'd5, 1'b0);
        offer(REQ_STEP, 5'd31, 5'd31, 1'b1);
        offer(REQ_READ, 5'd5, 5'd4, 1'b0);
        // Cells on the border of the area are gone after a step.
        offer(REQ_READ, 5'd0, 5'd0, 1'b0);
        offer(REQ_READ, 5'd29, 5'd29, 1'b0);
        offer(REQ_WRITE, 5'd5, 5'd5, 1'b0);
        offer(REQ_READ, 5'd5, 5'd5, 1'b1);
        settle_idle();

        // Full storage; the long result hold-off falls into this phase.
        program_size(6'd32, 6'd32);
        run_generations(160);
        settle_idle();

        // Smallest useful grid: a single inner cell. Cells kept from the large
        // grid outside it are not readable any more.
        program_size(6'd3, 6'd3);
        run_generations(40);
        settle_idle();

        // Size above storage is clipped to the storage size.
        program_size(6'd63, 6'd40);
        run_generations(80);
        settle_idle();

        // Below three columns there are no inner cells at all.
        program_size(6'd2, 6'd7);
        run_generations(25);
        settle_idle();

        // Zero columns: nothing is writable and every read gives 0.
        program_size(6'd0, 6'd63);
        run_generations(20);
        settle_idle();

        for (int p = 0; p < 4; p++) begin
            w = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 63))
                                            : CFG_W'($urandom_range(3, 32));
            h = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 63))
                                            : CFG_W'($urandom_range(3, 32));
            program_size(w, h);
            run_generations(60);
            settle_idle();
        end

        if (engine_model.errors == 0 && engine_model.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
sv/lgge_pkg.sv
sv/lgge_row_update.sv
sv/life_grid_generation_engine_top.sv
tb/tb_top.sv
